### design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset (rst_n is active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### design/tlps_pkg.sv
// Shared types, codes and coil tables for the thermal line print sequencer.
// No dependencies.
`default_nettype none

package tlps_pkg;

  localparam int LINE_BYTES_DEF = 24;
  localparam int LINE_COUNT_DEF = 8;

  // input function codes
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_PIXEL = 2'd1;
  localparam logic [1:0] FN_PRINT = 2'd2;
  localparam logic [1:0] FN_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_STEP   = 2'd0;
  localparam logic [1:0] CFG_STEPS_LINE  = 2'd1;
  localparam logic [1:0] CFG_STROBE_TCKS = 2'd2;
  localparam logic [1:0] CFG_STEP_TCKS   = 2'd3;

  localparam int CFG_DATA_W = 16;

  localparam logic       HALF_STEP_RST  = 1'b0;
  localparam logic [7:0] STEPS_LINE_RST = 8'd4;
  localparam logic [15:0] STROBE_RST    = 16'd1000;
  localparam logic [15:0] STEP_TCKS_RST = 16'd1000;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pixel_x;
    logic [2:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       latch_pulse;
    logic       strobe_on;
    logic       head_power;
    logic       coil_a;
    logic       coil_na;
    logic       coil_b;
    logic       coil_nb;
    logic       busy_res;
    logic       print_done;
  } out_word_t;

  // coil pattern bits: {A, /A, B, /B}
  function automatic logic [3:0] half_coil(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'b0010;
      3'd1:    c = 4'b1010;
      3'd2:    c = 4'b1000;
      3'd3:    c = 4'b1001;
      3'd4:    c = 4'b0001;
      3'd5:    c = 4'b0101;
      3'd6:    c = 4'b0100;
      default: c = 4'b0110;  // phase 8: B plus /A
    endcase
    return c;
  endfunction

  function automatic logic [3:0] full_coil(input logic [1:0] ph);
    logic [3:0] c;
    case (ph)
      2'd0:    c = 4'b1010;
      2'd1:    c = 4'b1001;
      2'd2:    c = 4'b0101;
      default: c = 4'b0110;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### design/thermal_line_print_sequencer_unit.sv
// Thermal printhead line sequencer: dot buffer memory, shift/latch/strobe/step control.
// Depends on tlps_pkg.
`default_nettype none

// One word in, one word out. After reset the dot buffer memory is swept to zero, one byte
// a cycle, all LINE_BYTES*LINE_COUNT bytes (192 by default), with in_stall high. Afterwards an
// item is accepted every cycle while the output side keeps up: the buffer read (pixel
// read-modify-write or byte shift) is a registered memory read, and its result sits in a pending
// stage that drains into the output register as the next word is taken. A pixel write-back
// and a read of the same byte in the same cycle are forwarded. A clear sweeps one byte per
// tick word; print timing is counted in tick words only.
module thermal_line_print_sequencer_unit
  import tlps_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int LINE_COUNT = LINE_COUNT_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  wire                    out_stall,
  output out_word_t              out_word,
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_idx,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int BUF_SIZE = LINE_BYTES * LINE_COUNT;
  localparam int AW       = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
  localparam int BI_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int LI_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int PS_W     = $clog2(32 + 7 * LINE_BYTES);
  localparam int BS_W     = $clog2(BUF_SIZE + 1);
  localparam int CMP_W    = (BS_W > PS_W) ? BS_W : PS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_LATCH  = 3'd3;
  localparam logic [2:0] ST_STROBE = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;
  localparam logic [2:0] ST_OFF    = 3'd6;

  // configuration
  logic        half_r;
  logic [7:0]  spl_r;
  logic [15:0] strobe_tk_r;
  logic [15:0] step_tk_r;

  // sequencer state
  logic [2:0]      stage_r, stage_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [3:0]      coil_r, coil_nxt;
  logic [LI_W-1:0] line_r, line_nxt;
  logic [BI_W-1:0] byte_r, byte_nxt;
  logic [15:0]     timer_r, timer_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [AW-1:0]   clr_idx_r, clr_idx_nxt;

  // reset sweep
  logic          init_r;
  logic [AW-1:0] init_idx_r;

  // pending stage (waits on memory read data)
  logic          pend_v_r;
  out_word_t     pend_res_r;
  logic          pend_shift_r;
  logic          pend_wr_r;
  logic [AW-1:0] pend_addr_r;
  logic [7:0]    pend_mask_r;

  logic      out_valid_r;
  out_word_t out_word_r;

  // memory
  logic [7:0]    mem [BUF_SIZE];
  logic [7:0]    rdata_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic          in_acc;
  logic          pend_go;
  logic          pend_wb;
  logic          clr_wr;
  logic          pix_rd;
  logic          shift_rd;
  logic          strobe;
  logic          latch;
  logic          done;
  logic [CMP_W-1:0] pix_sum;
  logic          pix_ok;
  logic [AW-1:0] shift_addr;
  logic [7:0]    rd_eff;
  out_word_t     res;
  out_word_t     merged;

  assign pend_go  = pend_v_r && (!out_valid_r || !out_stall);
  assign in_stall = init_r || (pend_v_r && !pend_go);
  assign in_acc   = in_valid && !in_stall;
  assign pend_wb  = pend_go && pend_wr_r;

  assign pix_sum = CMP_W'(in_word.pixel_x[7:3])
                 + CMP_W'(in_word.pixel_y) * CMP_W'(LINE_BYTES);
  assign pix_ok  = pix_sum < CMP_W'(BUF_SIZE);
  assign shift_addr = AW'(byte_r) + AW'(line_r) * AW'(LINE_BYTES);

  assign rd_eff = fwd_r ? fwd_data_r : rdata_r;

  always_comb begin
    stage_nxt   = stage_r;
    phase_nxt   = phase_r;
    coil_nxt    = coil_r;
    line_nxt    = line_r;
    byte_nxt    = byte_r;
    timer_nxt   = timer_r;
    rem_nxt     = rem_r;
    clr_idx_nxt = clr_idx_r;
    clr_wr      = 1'b0;
    pix_rd      = 1'b0;
    shift_rd    = 1'b0;
    strobe      = 1'b0;
    latch       = 1'b0;
    done        = 1'b0;
    if (in_acc) begin
      if (stage_r == ST_IDLE) begin
        case (in_word.func)
          FN_CLEAR: begin
            stage_nxt   = ST_CLEAR;
            clr_idx_nxt = '0;
          end
          FN_PIXEL: pix_rd = 1'b1;
          FN_PRINT: begin
            stage_nxt = ST_SHIFT;
            line_nxt  = '0;
            byte_nxt  = BI_W'(LINE_BYTES - 1);
          end
          default: ;
        endcase
      end else if (in_word.func == FN_TICK) begin
        case (stage_r)
          ST_CLEAR: begin
            clr_wr = 1'b1;
            if (clr_idx_r == AW'(BUF_SIZE - 1)) begin
              clr_idx_nxt = '0;
              stage_nxt   = ST_IDLE;
            end else begin
              clr_idx_nxt = clr_idx_r + 1'b1;
            end
          end
          ST_SHIFT: begin
            shift_rd = 1'b1;
            if (byte_r == '0) stage_nxt = ST_LATCH;
            else              byte_nxt  = byte_r - 1'b1;
          end
          ST_LATCH: begin
            latch     = 1'b1;
            timer_nxt = strobe_tk_r;
            stage_nxt = ST_STROBE;
          end
          ST_STROBE: begin
            if (timer_r != '0) begin
              strobe    = 1'b1;
              timer_nxt = timer_r - 1'b1;
            end
            if (timer_nxt == '0) begin
              rem_nxt   = spl_r;
              stage_nxt = (spl_r != '0) ? ST_STEP : ST_OFF;
            end
          end
          ST_STEP: begin
            if (timer_r == '0) begin
              if (half_r) begin
                coil_nxt  = half_coil(phase_r);
                phase_nxt = phase_r + 1'b1;
              end else if (!phase_r[2]) begin
                // full step beyond phase 4 leaves coils and phase alone
                coil_nxt  = full_coil(phase_r[1:0]);
                phase_nxt = {1'b0, phase_r[1:0] + 2'd1};
              end
              if (rem_r != '0) rem_nxt = rem_r - 1'b1;
              timer_nxt = step_tk_r;
            end else begin
              timer_nxt = timer_r - 1'b1;
            end
            if (timer_nxt == '0 && rem_nxt == '0) stage_nxt = ST_OFF;
          end
          ST_OFF: begin
            if (line_r == LI_W'(LINE_COUNT - 1)) begin
              line_nxt  = '0;
              done      = 1'b1;
              stage_nxt = ST_IDLE;
            end else begin
              line_nxt  = line_r + 1'b1;
              byte_nxt  = BI_W'(LINE_BYTES - 1);
              stage_nxt = ST_SHIFT;
            end
          end
          default: stage_nxt = ST_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res             = '0;
    res.byte_valid  = shift_rd;
    res.latch_pulse = latch;
    res.strobe_on   = strobe;
    res.head_power  = (stage_nxt == ST_STROBE) || (stage_nxt == ST_STEP)
                   || (stage_nxt == ST_OFF);
    res.coil_a      = coil_nxt[3];
    res.coil_na     = coil_nxt[2];
    res.coil_b      = coil_nxt[1];
    res.coil_nb     = coil_nxt[0];
    res.busy_res    = stage_nxt != ST_IDLE;
    res.print_done  = done;
  end

  always_comb begin
    merged          = pend_res_r;
    merged.byte_out = pend_shift_r ? rd_eff : 8'h00;
  end

  // memory ports: one read, one write; reset sweep wins, then pixel write-back
  assign rd_en   = pix_rd || shift_rd;
  assign rd_addr = pix_rd ? AW'(pix_sum) : shift_addr;
  assign wr_en   = init_r || pend_wb || clr_wr;

  always_comb begin
    if (init_r) begin
      wr_addr = init_idx_r;
      wr_data = 8'h00;
    end else if (pend_wb) begin
      wr_addr = pend_addr_r;
      wr_data = rd_eff | pend_mask_r;
    end else begin
      wr_addr = clr_idx_r;
      wr_data = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_r      <= pend_wb && (pend_addr_r == rd_addr);
      fwd_data_r <= rd_eff | pend_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_STEP_RST;
      spl_r       <= STEPS_LINE_RST;
      strobe_tk_r <= STROBE_RST;
      step_tk_r   <= STEP_TCKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HALF_STEP:   half_r      <= cfg_wdata[0];
        CFG_STEPS_LINE:  spl_r       <= cfg_wdata[7:0];
        CFG_STROBE_TCKS: strobe_tk_r <= cfg_wdata;
        CFG_STEP_TCKS:   step_tk_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_IDLE;
      phase_r     <= '0;
      coil_r      <= '0;
      line_r      <= '0;
      byte_r      <= '0;
      timer_r     <= '0;
      rem_r       <= '0;
      clr_idx_r   <= '0;
      init_r      <= 1'b1;
      init_idx_r  <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_r   <= stage_nxt;
      phase_r   <= phase_nxt;
      coil_r    <= coil_nxt;
      line_r    <= line_nxt;
      byte_r    <= byte_nxt;
      timer_r   <= timer_nxt;
      rem_r     <= rem_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (init_r) begin
        if (init_idx_r == AW'(BUF_SIZE - 1)) init_r <= 1'b0;
        init_idx_r <= init_idx_r + 1'b1;
      end
      if (in_acc)       pend_v_r <= 1'b1;
      else if (pend_go) pend_v_r <= 1'b0;
      if (pend_go)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_res_r   <= res;
      pend_shift_r <= shift_rd;
      pend_wr_r    <= pix_rd && pix_ok;
      pend_addr_r  <= AW'(pix_sum);
      pend_mask_r  <= 8'h80 >> in_word.pixel_x[2:0];
    end
    if (pend_go) begin
      out_word_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### design/tlps_checker.sv
// Port-level checks for the thermal line print sequencer, bound to the top level.
// Depends on tlps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlps_checker
  import tlps_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input out_word_t out_word
);

  // a stalled word holds
  `ASSERT_RST(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_word), "output word changed while stalled")
  // buffer sweep after reset keeps the input closed
  `ASSERT_CLK(a_init_stall, clk, !rst_n |=> in_stall, "input open right after reset")
  `ASSERT_RST(a_done_idle, clk, rst_n,
    out_valid && out_word.print_done |-> !out_word.busy_res, "print done while still busy")
  `ASSERT_RST(a_shift_unpowered, clk, rst_n,
    out_valid && out_word.byte_valid |-> !out_word.head_power && !out_word.latch_pulse,
    "shift word with head powered or latching")
  `ASSERT_RST(a_latch_power, clk, rst_n,
    out_valid && out_word.latch_pulse |-> out_word.head_power && out_word.busy_res,
    "latch without head power")

endmodule

bind thermal_line_print_sequencer_unit tlps_checker u_tlps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

### test/tb_thermal_line_print_sequencer_unit.sv
// Self-checking testbench for thermal_line_print_sequencer_unit: drives input words,
// predicts every output word from its own model of buffer, print and motor state.
// Depends on tlps_pkg and the block itself.
`timescale 1ns / 100ps

module tb_thermal_line_print_sequencer_unit
  import tlps_pkg::*;
();

  localparam int ROW_BYTES   = LINE_BYTES_DEF;
  localparam int ROW_COUNT   = LINE_COUNT_DEF;
  localparam int DOT_BYTES   = ROW_BYTES * ROW_COUNT;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_WORDS = 250;

  // coil patterns {A, /A, B, /B}, entry 0 in the low nibble
  localparam logic [31:0] HALF_PAT = {4'b0110, 4'b0100, 4'b0101, 4'b0001,
                                      4'b1001, 4'b1000, 4'b1010, 4'b0010};
  localparam logic [15:0] FULL_PAT = {4'b0110, 4'b0101, 4'b1001, 4'b1010};

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SHIFT, ST_LATCH, ST_STROBE, ST_STEP, ST_OFF
  } seq_stage_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [7:0]  dots [DOT_BYTES];
  seq_stage_t  stage_q;
  logic [2:0]  phase_q;
  logic [3:0]  coils_q;
  int          line_q;
  int          byte_q;
  logic [15:0] timer_q;
  logic [7:0]  steps_left;
  int          clr_idx;
  logic        half_cfg;
  logic [7:0]  steps_cfg;
  logic [15:0] strobe_cfg;
  logic [15:0] step_cfg;

  out_word_t pending_words [$];
  int        n_err;
  int        words_sent;
  int        quiet_cycles;
  bit        idle_en = 1'b1;

  thermal_line_print_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t make_word(input logic [1:0] f, input logic [7:0] x,
                                         input logic [2:0] y);
    in_word_t w;
    w.func    = f;
    w.pixel_x = x;
    w.pixel_y = y;
    return w;
  endfunction

  // Advance the print model by one input word and return the word it should produce.
  function automatic out_word_t next_head_word(input in_word_t w);
    out_word_t r;
    int addr;
    r = '0;
    if (stage_q == ST_IDLE) begin
      case (w.func)
        FN_CLEAR: begin
          stage_q = ST_CLEAR;
          clr_idx = 0;
        end
        FN_PIXEL: begin
          // column past the row end spills into the next row
          addr = int'(w.pixel_x) / 8 + int'(w.pixel_y) * ROW_BYTES;
          if (addr < DOT_BYTES) dots[addr] = dots[addr] | (8'h80 >> w.pixel_x[2:0]);
        end
        FN_PRINT: begin
          stage_q = ST_SHIFT;
          line_q  = 0;
          byte_q  = ROW_BYTES - 1;
        end
        default: ;
      endcase
    end else if (w.func == FN_TICK) begin
      case (stage_q)
        ST_CLEAR: begin
          if (clr_idx < DOT_BYTES) dots[clr_idx] = 8'h00;
          clr_idx++;
          if (clr_idx >= DOT_BYTES) begin
            clr_idx = 0;
            stage_q = ST_IDLE;
          end
        end
        ST_SHIFT: begin
          addr = byte_q + line_q * ROW_BYTES;
          if (addr < DOT_BYTES) r.byte_out = dots[addr];
          r.byte_valid = 1'b1;
          if (byte_q == 0) stage_q = ST_LATCH;
          else byte_q--;
        end
        ST_LATCH: begin
          r.latch_pulse = 1'b1;
          timer_q = strobe_cfg;
          stage_q = ST_STROBE;
        end
        ST_STROBE: begin
          if (timer_q != 16'd0) begin
            r.strobe_on = 1'b1;
            timer_q--;
          end
          if (timer_q == 16'd0) begin
            steps_left = steps_cfg;
            stage_q = (steps_left != 8'd0) ? ST_STEP : ST_OFF;
          end
        end
        ST_STEP: begin
          if (timer_q == 16'd0) begin
            if (half_cfg) begin
              coils_q = HALF_PAT[int'(phase_q) * 4 +: 4];
              phase_q = phase_q + 3'd1;
            end else if (phase_q < 3'd4) begin
              // full stepping leaves the motor alone in the upper half-step phases
              coils_q = FULL_PAT[int'(phase_q) * 4 +: 4];
              phase_q = {1'b0, phase_q[1:0] + 2'd1};
            end
            if (steps_left != 8'd0) steps_left--;
            timer_q = step_cfg;
          end else begin
            timer_q--;
          end
          if (timer_q == 16'd0 && steps_left == 8'd0) stage_q = ST_OFF;
        end
        ST_OFF: begin
          line_q++;
          if (line_q >= ROW_COUNT) begin
            line_q = 0;
            r.print_done = 1'b1;
            stage_q = ST_IDLE;
          end else begin
            byte_q  = ROW_BYTES - 1;
            stage_q = ST_SHIFT;
          end
        end
        default: stage_q = ST_IDLE;
      endcase
    end
    r.head_power = (stage_q == ST_STROBE || stage_q == ST_STEP || stage_q == ST_OFF);
    r.coil_a     = coils_q[3];
    r.coil_na    = coils_q[2];
    r.coil_b     = coils_q[1];
    r.coil_nb    = coils_q[0];
    r.busy_res   = (stage_q != ST_IDLE);
    return r;
  endfunction

  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_words.push_back(next_head_word(w));
    words_sent++;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(make_word(FN_TICK, 8'($urandom), 3'($urandom)));
  endtask

  task automatic send_pixel(input logic [7:0] x, input logic [2:0] y);
    send_word(make_word(FN_PIXEL, x, y));
  endtask

  // Tick until the model is idle; noise_pct percent of the words are random functions.
  task automatic run_to_idle(input int noise_pct);
    while (stage_q != ST_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_word(make_word(2'($urandom), 8'($urandom), 3'($urandom)));
      else
        send_tick();
    end
  endtask

  // Hold the sender until every predicted word has come back, then let the pipe settle.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HALF_STEP:   half_cfg   = val[0];
      CFG_STEPS_LINE:  steps_cfg  = val[7:0];
      CFG_STROBE_TCKS: strobe_cfg = val;
      default:         step_cfg   = val;
    endcase
  endtask

  task automatic set_timing(input logic half, input logic [7:0] steps,
                            input logic [15:0] strobe, input logic [15:0] hold);
    wait_drained();
    cfg_write(CFG_HALF_STEP, {15'd0, half});
    cfg_write(CFG_STEPS_LINE, {8'd0, steps});
    cfg_write(CFG_STROBE_TCKS, strobe);
    cfg_write(CFG_STEP_TCKS, hold);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : check_out
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected output word: expected none, got %h", $time, out_word);
        n_err++;
      end else begin
        exp_w = pending_words.pop_front();
        cmp_field("byte_out", exp_w.byte_out, out_word.byte_out);
        cmp_field("byte_valid", exp_w.byte_valid, out_word.byte_valid);
        cmp_field("latch_pulse", exp_w.latch_pulse, out_word.latch_pulse);
        cmp_field("strobe_on", exp_w.strobe_on, out_word.strobe_on);
        cmp_field("head_power", exp_w.head_power, out_word.head_power);
        cmp_field("coil_a", exp_w.coil_a, out_word.coil_a);
        cmp_field("coil_na", exp_w.coil_na, out_word.coil_na);
        cmp_field("coil_b", exp_w.coil_b, out_word.coil_b);
        cmp_field("coil_nb", exp_w.coil_nb, out_word.coil_nb);
        cmp_field("busy_res", exp_w.busy_res, out_word.busy_res);
        cmp_field("print_done", exp_w.print_done, out_word.print_done);
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_pixel_map();
    send_tick();  // tick while idle only reports state
    set_timing(1'b0, 8'd2, 16'd3, 16'd1);
    send_pixel(8'd0, 3'd0);
    send_pixel(8'd191, 3'd7);
    send_pixel(8'd255, 3'd0);  // spills into row 1
    send_pixel(8'd255, 3'd7);  // past buffer end, dropped
    send_pixel(8'd7, 3'd3);
    send_pixel(8'd128, 3'd4);
    send_pixel(8'd0, 3'd0);
    send_pixel(8'd1, 3'd0);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    send_tick();
    // non-tick words while printing are ignored
    send_pixel(8'd2, 3'd1);
    send_word(make_word(FN_CLEAR, 8'hff, 3'd7));
    send_word(make_word(FN_PRINT, 8'h00, 3'd0));
    run_to_idle(0);
  endtask

  task automatic test_clear_sweep();
    send_pixel(8'd100, 3'd2);
    send_pixel(8'd63, 3'd5);
    send_word(make_word(FN_CLEAR, 8'd0, 3'd0));
    send_pixel(8'd10, 3'd0);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(20);
    send_pixel(8'd33, 3'd6);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
  endtask

  task automatic test_half_step_cycle();
    // one half step per row walks all eight phases, phase 8 included; strobe of zero
    set_timing(1'b1, 8'd1, 16'd0, 16'd2);
    send_pixel(8'd12, 3'd1);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
    set_timing(1'b1, 8'd3, 16'd1, 16'd0);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
  endtask

  task automatic test_step_count_extremes();
    set_timing(1'b0, 8'd10, 16'd1, 16'd0);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
    set_timing(1'b0, 8'd0, 16'd5, 16'd3);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0)
        set_timing(1'($urandom), 8'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 3)));
      repeat ($urandom_range(0, 24)) send_pixel(8'($urandom), 3'($urandom));
      case ($urandom_range(0, 9))
        0: begin
          send_word(make_word(FN_CLEAR, 8'($urandom), 3'($urandom)));
          run_to_idle(10);
        end
        1, 2: begin
          // loose words; anything they start is run out
          repeat ($urandom_range(1, 10))
            send_word(make_word(2'($urandom), 8'($urandom), 3'($urandom)));
          run_to_idle(10);
        end
        default: begin
          send_word(make_word(FN_PRINT, 8'($urandom), 3'($urandom)));
          run_to_idle(5);
        end
      endcase
    end
    idle_en = 1'b1;
  endtask

  task automatic test_long_strobe();
    idle_en = 1'b0;
    set_timing(1'b1, 8'd0, 16'd20, 16'hffff);
    send_pixel(8'd190, 3'd7);
    send_word(make_word(FN_PRINT, 8'd0, 3'd0));
    run_to_idle(0);
  endtask

  initial begin
    n_err      = 0;
    words_sent = 0;
    for (int i = 0; i < DOT_BYTES; i++) dots[i] = 8'h00;
    stage_q    = ST_IDLE;
    phase_q    = 3'd0;
    coils_q    = 4'd0;
    line_q     = 0;
    byte_q     = 0;
    timer_q    = 16'd0;
    steps_left = 8'd0;
    clr_idx    = 0;
    half_cfg   = HALF_STEP_RST;
    steps_cfg  = STEPS_LINE_RST;
    strobe_cfg = STROBE_RST;
    step_cfg   = STEP_TCKS_RST;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_HALF_STEP;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_pixel_map();
    test_clear_sweep();
    test_half_step_cycle();
    test_step_count_extremes();
    test_random_traffic();
    test_long_strobe();

    wait_drained();
    repeat (16) @(posedge clk);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
